@@ hdl/modexp_pkg.sv @@
// package for the modular exponentiation block
// default data width and the byte padding rule for stream data buses
// no dependencies
package modexp_pkg;

  localparam int DEF_WIDTH = 32;

  function automatic int byte_pad(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

@@ hdl/modexp_mulmod.sv @@
// shared modular multiplier: one full product, then bit-serial restoring reduction
// depends on modexp_pkg for the default width
// result is valid when done pulses; modulus must be nonzero and held steady
module modexp_mulmod #(
  parameter int WIDTH = modexp_pkg::DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  input  logic [WIDTH-1:0] modulus,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int PROD_W = 2 * WIDTH;
  localparam int CNT_W  = $clog2(PROD_W);

  typedef enum logic {
    ST_IDLE,
    ST_RED
  } state_t;

  state_t            state;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] product;
  logic [WIDTH-1:0]  rem;
  logic [WIDTH-1:0]  rem_next;
  logic [CNT_W-1:0]  cnt;
  logic [WIDTH:0]    trial;
  logic [WIDTH:0]    diff;
  logic              fits;

  assign product  = PROD_W'(op_a) * PROD_W'(op_b);
  assign trial    = {rem, prod[PROD_W-1]};
  assign fits     = trial >= {1'b0, modulus};
  assign diff     = trial - {1'b0, modulus};
  assign rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
  assign result   = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            prod  <= product;
            rem   <= '0;
            cnt   <= CNT_W'(PROD_W - 1);
            state <= ST_RED;
          end
        end
        ST_RED: begin
          rem  <= rem_next;
          prod <= prod << 1;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("mulmod done held for more than one cycle");
  a_reduced: assert property (@(posedge clk) disable iff (rst) done |-> (result < modulus))
    else $error("mulmod result not reduced below modulus");

endmodule

@@ hdl/modexp_seq.sv @@
// square-and-multiply sequencer: holds base, exponent and running result
// depends on modexp_pkg and drives one shared modexp_mulmod unit
module modexp_seq #(
  parameter int WIDTH = modexp_pkg::DEF_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_base,
  input  logic [WIDTH-1:0] in_exp,
  input  logic [WIDTH-1:0] in_mod,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [WIDTH-1:0] res_value,
  output logic             res_bad,
  output logic             mm_start,
  output logic [WIDTH-1:0] mm_a,
  output logic [WIDTH-1:0] mm_b,
  output logic [WIDTH-1:0] mm_mod,
  input  logic             mm_done,
  input  logic [WIDTH-1:0] mm_result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_WMUL,
    ST_WSQR,
    ST_OUT
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] expo;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] op_a;
  logic             start;

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_OUT);
  assign mm_start  = start;
  assign mm_a      = op_a;
  assign mm_b      = base;
  assign mm_mod    = modulus;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      start <= 1'b0;
    end else begin
      start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            base    <= in_base;
            expo    <= in_exp;
            modulus <= in_mod;
            if (in_mod == '0) begin
              res_value <= '0;
              res_bad   <= 1'b1;
              state     <= ST_OUT;
            end else begin
              acc     <= WIDTH'(1);
              res_bad <= 1'b0;
              state   <= ST_STEP;
            end
          end
        end
        ST_STEP: begin
          if (expo == '0) begin
            res_value <= acc;
            state     <= ST_OUT;
          end else if (expo[0]) begin
            op_a  <= acc;
            start <= 1'b1;
            state <= ST_WMUL;
          end else begin
            op_a  <= base;
            start <= 1'b1;
            state <= ST_WSQR;
          end
        end
        ST_WMUL: begin
          if (mm_done) begin
            acc   <= mm_result;
            op_a  <= base;
            start <= 1'b1;
            state <= ST_WSQR;
          end
        end
        ST_WSQR: begin
          if (mm_done) begin
            base  <= mm_result;
            expo  <= expo >> 1;
            state <= ST_STEP;
          end
        end
        ST_OUT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_mod_held: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> $stable(modulus))
    else $error("modulus changed while a request was in progress");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_bad) |-> (res_value == '0))
    else $error("error result carries a nonzero value");
  a_start_wait: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == ST_WMUL || state == ST_WSQR))
    else $error("multiplier started outside a wait state");

endmodule

@@ hdl/modexp_top.sv @@
// Modular exponentiation, base^exponent mod modulus, by right-to-left square-and-multiply.
// One request is taken at a time: s_axis_tready is high only while the block is idle, and
// a finished result sits in the output register so the next request can be taken while it
// waits. The time per request is set by the single shared modular multiplier, which forms
// the full product and reduces it one bit per cycle. Each exponent bit up to the highest
// set one costs a squaring, plus a multiply when the bit is set. A zero exponent returns 1;
// a zero modulus returns 0 with the error flag in tuser set.
// depends on modexp_pkg, modexp_seq and modexp_mulmod
module modular_exponentiation_top #(
  parameter int WIDTH = modexp_pkg::DEF_WIDTH
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // base_value, exponent, modulus
  input  logic [modexp_pkg::byte_pad(3*WIDTH)-1:0]   s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // power_mod
  output logic [modexp_pkg::byte_pad(WIDTH)-1:0]     m_axis_tdata,
  // bad_modulus
  output logic                                       m_axis_tuser
);

  import modexp_pkg::*;

  localparam int OUT_W = byte_pad(WIDTH);

  logic             res_valid;
  logic             res_ready;
  logic [WIDTH-1:0] res_value;
  logic             res_bad;
  logic             mm_start;
  logic [WIDTH-1:0] mm_a;
  logic [WIDTH-1:0] mm_b;
  logic [WIDTH-1:0] mm_mod;
  logic             mm_done;
  logic [WIDTH-1:0] mm_result;
  logic [WIDTH-1:0] power_mod;
  logic             bad_modulus;
  logic             out_valid;

  modexp_seq #(.WIDTH(WIDTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_base   (s_axis_tdata[WIDTH-1:0]),
    .in_exp    (s_axis_tdata[2*WIDTH-1:WIDTH]),
    .in_mod    (s_axis_tdata[3*WIDTH-1:2*WIDTH]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_value (res_value),
    .res_bad   (res_bad),
    .mm_start  (mm_start),
    .mm_a      (mm_a),
    .mm_b      (mm_b),
    .mm_mod    (mm_mod),
    .mm_done   (mm_done),
    .mm_result (mm_result)
  );

  modexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .op_a    (mm_a),
    .op_b    (mm_b),
    .modulus (mm_mod),
    .done    (mm_done),
    .result  (mm_result)
  );

  // output register
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid   <= 1'b1;
        power_mod   <= res_value;
        bad_modulus <= res_bad;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'(power_mod);
  assign m_axis_tuser  = bad_modulus;

endmodule
